>>> design/itse_pkg.sv
package itse_pkg;

	localparam logic [4:0] STR_LEN = 5'd22;
	localparam logic [4:0] POS_SAT = 5'd23;

	localparam logic [7:0] CH_TWO   = 8'h32;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_Z     = 8'h5A;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [16:0] K_VAL_ONE   = 17'd1;
	localparam logic [16:0] K_VAL_MIN   = 17'd60;
	localparam logic [16:0] K_VAL_HOUR  = 17'd3600;
	localparam logic [16:0] K_VAL_YEAR  = 17'd365;
	localparam logic [16:0] K_VAL_DAY   = 17'd86400;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} in_t;

	typedef struct packed {
		logic        accepted;
		logic        clock_set;
		logic [15:0] days_since_2000;
		logic [31:0] seconds_since_2000;
		logic [3:0]  weekday;
	} out_t;

	typedef struct packed {
		logic [7:0] year;
		logic [7:0] month;
		logic [7:0] day;
		logic [7:0] hour;
		logic [7:0] minute;
		logic [7:0] second;
	} bcd_fields_t;

	typedef struct packed {
		logic commit;
		logic done;
	} calc_stat_t;

	typedef struct packed {
		logic       is_digit;
		logic [3:0] idx;
	} slot_t;

	typedef enum logic [3:0] {
		OPND_ZERO,
		OPND_YEAR,
		OPND_YQ,
		OPND_MPART,
		OPND_DAY,
		OPND_DAYS,
		OPND_HOUR,
		OPND_MIN,
		OPND_SEC
	} opnd_t;

	typedef enum logic [2:0] {
		K_ONE,
		K_SIXTY,
		K_HOUR,
		K_YEAR,
		K_DAY
	} kmul_t;

	typedef enum logic [1:0] {
		J_NONE,
		J_UNSET,
		J_ALWAYS
	} jump_t;

	typedef struct packed {
		opnd_t      opnd;
		kmul_t      kmul;
		logic       acc_en;
		logic       acc_clr;
		logic       day_ld;
		logic       day_clr;
		logic       commit;
		jump_t      jump;
		logic [3:0] target;
		logic       last;
	} uword_t;

	localparam logic [3:0] STEP_ZERO_OUT = 4'd11;
	localparam logic [3:0] STEP_EMIT     = 4'd12;

	// digit slot of each string position
	function automatic slot_t slot_of_pos(input logic [4:0] pos);
		slot_t s;
		s.is_digit = 1'b1;
		s.idx      = 4'd0;
		case (pos)
			5'd2:    s.idx = 4'd0;
			5'd3:    s.idx = 4'd1;
			5'd5:    s.idx = 4'd2;
			5'd6:    s.idx = 4'd3;
			5'd8:    s.idx = 4'd4;
			5'd9:    s.idx = 4'd5;
			5'd11:   s.idx = 4'd6;
			5'd12:   s.idx = 4'd7;
			5'd14:   s.idx = 4'd8;
			5'd15:   s.idx = 4'd9;
			5'd17:   s.idx = 4'd10;
			5'd18:   s.idx = 4'd11;
			5'd21:   s.idx = 4'd12;
			default: s.is_digit = 1'b0;
		endcase
		return s;
	endfunction

	// separator expected at each fixed position
	function automatic logic [7:0] fixed_char(input logic [4:0] pos);
		logic [7:0] c;
		c = 8'h00;
		case (pos)
			5'd0:    c = CH_TWO;
			5'd1:    c = CH_ZERO;
			5'd4:    c = CH_DASH;
			5'd7:    c = CH_DASH;
			5'd10:   c = CH_T;
			5'd13:   c = CH_COLON;
			5'd16:   c = CH_COLON;
			5'd19:   c = CH_Z;
			5'd20:   c = CH_UNDER;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [6:0] bcd_value(input logic [7:0] b);
		return 7'({3'b000, b[7:4]} * 7'd10) + {3'b000, b[3:0]};
	endfunction

	// days in the months before month mo
	function automatic logic [11:0] month_offset(input logic [6:0] mo, input logic leap);
		logic [6:0]  n;
		logic [6:0]  k;
		logic [11:0] base;
		n = (mo == 7'd0) ? 7'd0 : mo - 7'd1;
		k = n - 7'd7;
		case (n)
			7'd0:    base = 12'd0;
			7'd1:    base = 12'd31;
			7'd2:    base = 12'd59;
			7'd3:    base = 12'd90;
			7'd4:    base = 12'd120;
			7'd5:    base = 12'd151;
			7'd6:    base = 12'd181;
			7'd7:    base = 12'd212;
			default: base = 12'd212 + 12'({5'b00000, k} * 12'd30) + {5'b00000, (k + 7'd1) >> 1};
		endcase
		if (leap && n >= 7'd2)
			base = base + 12'd1;
		return base;
	endfunction

	localparam uword_t UW_NOP = '{
		opnd:    OPND_ZERO,
		kmul:    K_ONE,
		acc_en:  1'b0,
		acc_clr: 1'b0,
		day_ld:  1'b0,
		day_clr: 1'b0,
		commit:  1'b0,
		jump:    J_NONE,
		target:  4'd0,
		last:    1'b0
	};

	// microprogram run once per string after its final character
	function automatic uword_t ucode(input logic [3:0] step);
		uword_t w;
		w = UW_NOP;
		case (step)
			4'd0: w.commit = 1'b1;
			4'd1: begin
				w.jump   = J_UNSET;
				w.target = STEP_ZERO_OUT;
			end
			4'd2: begin
				w.opnd    = OPND_YEAR;
				w.kmul    = K_YEAR;
				w.acc_en  = 1'b1;
				w.acc_clr = 1'b1;
			end
			4'd3: begin
				w.opnd   = OPND_YQ;
				w.acc_en = 1'b1;
			end
			4'd4: begin
				w.opnd   = OPND_MPART;
				w.acc_en = 1'b1;
			end
			4'd5: begin
				w.opnd   = OPND_DAY;
				w.acc_en = 1'b1;
			end
			4'd6: w.day_ld = 1'b1;
			4'd7: begin
				w.opnd    = OPND_DAYS;
				w.kmul    = K_DAY;
				w.acc_en  = 1'b1;
				w.acc_clr = 1'b1;
			end
			4'd8: begin
				w.opnd   = OPND_HOUR;
				w.kmul   = K_HOUR;
				w.acc_en = 1'b1;
			end
			4'd9: begin
				w.opnd   = OPND_MIN;
				w.kmul   = K_SIXTY;
				w.acc_en = 1'b1;
			end
			4'd10: begin
				w.opnd   = OPND_SEC;
				w.acc_en = 1'b1;
				w.jump   = J_ALWAYS;
				w.target = STEP_EMIT;
			end
			4'd11: begin
				w.acc_en  = 1'b1;
				w.acc_clr = 1'b1;
				w.day_clr = 1'b1;
			end
			default: w.last = 1'b1;
		endcase
		return w;
	endfunction

endpackage

>>> design/itse_stream_if.sv
interface itse_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

>>> design/itse_calc.sv
module itse_calc (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   run,
	input  logic                   go,
	input  itse_pkg::bcd_fields_t  fields,
	input  logic                   time_valid,
	output itse_pkg::calc_stat_t   stat,
	output logic [15:0]            days,
	output logic [31:0]            secs
);

	logic [3:0]       step_q;
	itse_pkg::uword_t uw;
	logic [6:0]       yr;
	logic [5:0]       yq;
	logic [11:0]      mpart;
	logic [15:0]      opnd_val;
	logic [16:0]      kval;
	logic [32:0]      prod;
	logic [31:0]      acc_q;
	logic [15:0]      days_q;
	logic             take_jump;

	assign uw = itse_pkg::ucode(step_q);

	assign yr    = itse_pkg::bcd_value(fields.year);
	assign yq    = 6'(({1'b0, yr} + 8'd3) >> 2);
	assign mpart = itse_pkg::month_offset(itse_pkg::bcd_value(fields.month), yr[1:0] == 2'b00);

	always_comb begin
		case (uw.opnd)
			itse_pkg::OPND_YEAR:  opnd_val = {9'd0, yr};
			itse_pkg::OPND_YQ:    opnd_val = {10'd0, yq};
			itse_pkg::OPND_MPART: opnd_val = {4'd0, mpart};
			itse_pkg::OPND_DAY:   opnd_val = {9'd0, itse_pkg::bcd_value(fields.day)};
			itse_pkg::OPND_DAYS:  opnd_val = days_q;
			itse_pkg::OPND_HOUR:  opnd_val = {9'd0, itse_pkg::bcd_value(fields.hour)};
			itse_pkg::OPND_MIN:   opnd_val = {9'd0, itse_pkg::bcd_value(fields.minute)};
			itse_pkg::OPND_SEC:   opnd_val = {9'd0, itse_pkg::bcd_value(fields.second)};
			default:              opnd_val = 16'd0;
		endcase
	end

	always_comb begin
		case (uw.kmul)
			itse_pkg::K_SIXTY: kval = itse_pkg::K_VAL_MIN;
			itse_pkg::K_HOUR:  kval = itse_pkg::K_VAL_HOUR;
			itse_pkg::K_YEAR:  kval = itse_pkg::K_VAL_YEAR;
			itse_pkg::K_DAY:   kval = itse_pkg::K_VAL_DAY;
			default:           kval = itse_pkg::K_VAL_ONE;
		endcase
	end

	assign prod = {17'd0, opnd_val} * {16'd0, kval};

	assign take_jump = (uw.jump == itse_pkg::J_ALWAYS) ||
		(uw.jump == itse_pkg::J_UNSET && !time_valid);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 4'd0;
		end else if (!run) begin
			step_q <= 4'd0;
		end else if (uw.last) begin
			if (go)
				step_q <= 4'd0;
		end else if (take_jump) begin
			step_q <= uw.target;
		end else begin
			step_q <= step_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (run && uw.acc_en)
			acc_q <= uw.acc_clr ? prod[31:0] : acc_q + prod[31:0];
		if (run && uw.day_clr)
			days_q <= 16'd0;
		else if (run && uw.day_ld)
			days_q <= acc_q[15:0] - 16'd1;
	end

	assign stat = '{commit: run && uw.commit, done: run && uw.last && go};
	assign days = days_q;
	assign secs = acc_q;

endmodule

>>> design/iso_timestamp_to_epoch_seconds_top.sv
// Parses "20YY-MM-DDThh:mm:ssZ_w" one character per transfer and, on the character
// flagged last, returns one result: whether the string was accepted (exactly 22
// characters, all separators in place), the clock-set flag, and the stored time as
// days (mod 2^16) and seconds (mod 2^32) since 2000-01-01 plus the weekday digit.
// Non-digits in digit places read as 0; a rejected string keeps the old time.
// Ordinary characters take one cycle each. After the last character a microcoded
// sequencer driving one 16x17 multiply-accumulate runs its steps, or a short path
// zeroing the time if the clock was never set; characters are not taken meanwhile.
// The result waits in an output register until taken, while the next string can start.
module iso_timestamp_to_epoch_seconds_top (
	input  logic          clk,
	input  logic          arst_n,
	itse_stream_if.sink   chars,
	itse_stream_if.source result
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t                state_q;
	logic [4:0]            pos_q;
	logic                  fmt_q;
	logic [3:0]            pend_q [13];
	itse_pkg::bcd_fields_t fields_q;
	logic [3:0]            weekday_q;
	logic                  time_valid_q;
	logic                  ok_q;
	logic                  out_valid_q;
	itse_pkg::out_t        out_q;

	logic                  in_xfer;
	logic                  ok;
	logic                  go;
	itse_pkg::slot_t       slot;
	logic [7:0]            ch;
	logic                  is_num;
	itse_pkg::calc_stat_t  stat;
	logic [15:0]           days;
	logic [31:0]           secs;

	assign chars.ready = (state_q == ST_IDLE);
	assign in_xfer     = chars.valid && chars.ready;
	assign ch          = chars.payload.char_code;
	assign slot        = itse_pkg::slot_of_pos(pos_q);
	assign is_num      = (ch >= itse_pkg::CH_ZERO) && (ch <= itse_pkg::CH_NINE);
	assign ok          = (pos_q == itse_pkg::STR_LEN) && fmt_q;
	assign go          = !out_valid_q || result.ready;

	itse_calc u_calc (
		.clk        (clk),
		.arst_n     (arst_n),
		.run        (state_q == ST_RUN),
		.go         (go),
		.fields     (fields_q),
		.time_valid (time_valid_q),
		.stat       (stat),
		.days       (days),
		.secs       (secs)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pos_q        <= 5'd0;
			fmt_q        <= 1'b1;
			pend_q       <= '{default: 4'd0};
			fields_q     <= '0;
			weekday_q    <= 4'd0;
			time_valid_q <= 1'b0;
			ok_q         <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (pos_q < itse_pkg::STR_LEN) begin
							if (slot.is_digit)
								pend_q[slot.idx] <= is_num ? ch[3:0] : 4'd0;
							else if (ch != itse_pkg::fixed_char(pos_q))
								fmt_q <= 1'b0;
						end
						if (pos_q < itse_pkg::POS_SAT)
							pos_q <= pos_q + 5'd1;
						if (chars.payload.last_char)
							state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (stat.commit) begin
						ok_q  <= ok;
						pos_q <= 5'd0;
						fmt_q <= 1'b1;
						if (ok) begin
							fields_q     <= '{
								year:   {pend_q[0], pend_q[1]},
								month:  {pend_q[2], pend_q[3]},
								day:    {pend_q[4], pend_q[5]},
								hour:   {pend_q[6], pend_q[7]},
								minute: {pend_q[8], pend_q[9]},
								second: {pend_q[10], pend_q[11]}
							};
							weekday_q    <= pend_q[12];
							time_valid_q <= 1'b1;
						end
					end
					if (stat.done)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (stat.done)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (stat.done) begin
			out_q.accepted           <= ok_q;
			out_q.clock_set          <= time_valid_q;
			out_q.days_since_2000    <= days;
			out_q.seconds_since_2000 <= secs;
			out_q.weekday            <= weekday_q;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.payload = out_q;

	a_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |-> state_q == ST_RUN)
		else $error("sequencer finished outside a run");

	a_last_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && chars.payload.last_char) |=> (state_q == ST_RUN && !chars.ready))
		else $error("last character did not start the sequencer");

	a_accept_sets_clock: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.payload.accepted) |-> result.payload.clock_set)
		else $error("accepted string without clock set");

	a_unset_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.payload.clock_set) |->
			(result.payload.days_since_2000 == 16'd0 &&
			result.payload.seconds_since_2000 == 32'd0))
		else $error("nonzero time while clock unset");

	a_commit_resets_pos: assert property (@(posedge clk) disable iff (!arst_n)
		stat.commit |=> (pos_q == 5'd0 && fmt_q))
		else $error("position not restarted after commit");

endmodule
